/* rtl/pip_pkg.sv */
// Shared types, constants and helpers for the point-in-polygon tolerance unit.
// Used by every module under rtl/; depends on nothing else.
package pip_pkg;

	// Sizing
	localparam int MAX_VERTICES = 16;
	localparam int COORD_BITS   = 16;
	localparam int FLD_W        = 16;
	localparam int CW           = (COORD_BITS < FLD_W) ? COORD_BITS : FLD_W;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W        = 4;
	localparam int VC_W         = 5;
	localparam int TOL_W        = 15;
	localparam int CFG_W        = 15;
	localparam int CFG_IDX_W    = 1;
	localparam int DW           = FLD_W + 1;
	localparam int MW           = 2 * DW;
	localparam int PW           = 2 * MW;
	localparam int MIN_VERTICES = 3;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(51);

	// Input word modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = CFG_IDX_W'(1);

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE, S_TOL, S_LDA, S_LDB, S_DIFF, S_SQA, S_SQB,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
		S_XSUB, S_CASE, S_BIG1, S_BIG2, S_NEXT, S_DONE
	} st_t;

	typedef logic signed [DW-1:0] crd_t;

	// Multiplier issue
	typedef struct packed {
		logic                 en;
		logic signed [MW-1:0] a;
		logic signed [MW-1:0] b;
	} mul_req_t;

	// Vertex store write and read ports
	typedef struct packed {
		logic              we;
		logic [VIDX_W-1:0] addr;
		logic [2*FLD_W-1:0] data;
	} vm_wr_t;

	typedef struct packed {
		logic              re;
		logic [VIDX_W-1:0] addr;
	} vm_rd_t;

	// Query start toward the sequencer
	typedef struct packed {
		logic             start;
		logic [FLD_W-1:0] x;
		logic [FLD_W-1:0] y;
	} qry_t;

	// Sequencer status
	typedef struct packed {
		logic busy;
		logic valid;
		logic in_poly;
		logic by_tol;
	} core_st_t;

	// Take the low CW bits of a coordinate as signed, widened to DW bits
	function automatic crd_t sx(input logic [FLD_W-1:0] v);
		return {{(DW-CW){v[CW-1]}}, v[CW-1:0]};
	endfunction

endpackage

/* rtl/point_in_polygon_with_tolerance_unit.sv */
// A query with n >= 3 vertices in use walks every edge of the ring, plus S_BIG1 and S_BIG2
// for each edge whose projection falls strictly inside the segment; the shared 34x34
// multiplier issues one product per cycle. Fewer than three vertices: the sequencer
// goes straight to its done state. Loads never busy the unit. A result enters the
// output register when free or draining; a new word is taken while a result waits there.
// arst_n clears control state, vertex_count to 0, tolerance to 51; vertices stay undefined.
module point_in_polygon_with_tolerance_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pip_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pip_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [pip_pkg::IDX_W-1:0]           vertex_index,
	input  logic signed [pip_pkg::FLD_W-1:0]    coord_x,
	input  logic signed [pip_pkg::FLD_W-1:0]    coord_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                inside_res,
	output logic                                by_tolerance
);
	import pip_pkg::*;

	logic [VC_W-1:0]  vertex_count_q;
	logic [TOL_W-1:0] tolerance_q;
	logic             out_valid_q, inside_q, by_tol_q;
	logic             in_acc, res_take;

	vm_wr_t               vwr;
	vm_rd_t               vrd;
	qry_t                 qry;
	core_st_t             cst;
	mul_req_t             mreq;
	logic signed [PW-1:0] prod;
	logic [2*FLD_W-1:0]   rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			tolerance_q    <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data[VC_W-1:0];
				REG_TOLERANCE:    tolerance_q    <= cfg_data[TOL_W-1:0];
			endcase
		end
	end

	// Input word: load goes straight to the store, query starts the sequencer
	assign in_stall = cst.busy;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		vwr.we    = in_acc && (mode == MODE_LOAD) && (int'(vertex_index) < MAX_VERTICES);
		vwr.addr  = VIDX_W'(vertex_index);
		vwr.data  = {coord_y, coord_x};
		qry.start = in_acc && (mode == MODE_QUERY);
		qry.x     = coord_x;
		qry.y     = coord_y;
	end

	pip_vmem u_vmem (
		.clk   (clk),
		.wr    (vwr),
		.rd    (vrd),
		.rdata (rdata)
	);

	pip_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	pip_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.qry          (qry),
		.vertex_count (vertex_count_q),
		.tolerance    (tolerance_q),
		.res_take     (res_take),
		.st           (cst),
		.mreq         (mreq),
		.prod         (prod),
		.rreq         (vrd),
		.rdata        (rdata)
	);

	// Output register: take a result when empty or being drained
	assign res_take = cst.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			inside_q <= cst.in_poly;
			by_tol_q <= cst.by_tol;
		end
	end

	assign out_valid    = out_valid_q;
	assign inside_res   = inside_q;
	assign by_tolerance = by_tol_q;

endmodule

/* rtl/pip_vmem.sv */
// Vertex store: one write port, one registered read port.
// Depends on pip_pkg.
module pip_vmem (
	input  logic                        clk,
	input  pip_pkg::vm_wr_t             wr,
	input  pip_pkg::vm_rd_t             rd,
	output logic [2*pip_pkg::FLD_W-1:0] rdata
);
	import pip_pkg::*;

	logic [2*FLD_W-1:0] mem_q [MAX_VERTICES];
	logic [2*FLD_W-1:0] rdata_q;

	// Write one vertex, register read data
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rdata_q <= mem_q[rd.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pip_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on pip_pkg.
module pip_mul (
	input  logic                           clk,
	input  pip_pkg::mul_req_t              req,
	output logic signed [pip_pkg::PW-1:0]  prod
);
	import pip_pkg::*;

	logic signed [PW-1:0] prod_q;

	// Issue one product per cycle, hold otherwise
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

	assign prod = prod_q;

endmodule

/* rtl/pip_core.sv */
// Query sequencer and edge datapath: walks the closed ring one edge at a time
// through the shared multiplier. Depends only on pip_pkg; its ports drive pip_mul and pip_vmem.
module pip_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pip_pkg::qry_t                  qry,
	input  logic [pip_pkg::VC_W-1:0]       vertex_count,
	input  logic [pip_pkg::TOL_W-1:0]      tolerance,
	input  logic                           res_take,
	output pip_pkg::core_st_t              st,
	output pip_pkg::mul_req_t              mreq,
	input  logic signed [pip_pkg::PW-1:0]  prod,
	output pip_pkg::vm_rd_t                rreq,
	input  logic [2*pip_pkg::FLD_W-1:0]    rdata
);
	import pip_pkg::*;

	st_t state_q, state_d;

	crd_t px_q, py_q, ax_q, ay_q, bx_q, by_q;
	crd_t dx_q, dy_q, wx_q, wy_q;
	logic signed [MW-1:0] len2_q, dot_q, cross_q, d2a_q, d2b_q, tt_q;
	logic [PW-2:0]        crsq_q;
	logic                 strad_q, first_q, lo_q, intr_q;
	logic                 crossing_q, onb_q, near_q;
	logic [CNT_W-1:0]     cnt_q, nb_q;

	logic [CNT_W-1:0]     n, nb_nx, nb_inc;
	logic                 few, last;
	logic signed [MW-1:0] pl, d2_sel;
	logic signed [MW+1:0] d2b_w;
	logic                 lo_w, intr_w, dy_pos, cross_pos;

	// Vertices in use, saturated to the store depth
	always_comb begin
		if (int'(vertex_count) > MAX_VERTICES) begin
			n = CNT_W'(MAX_VERTICES);
		end else begin
			n = CNT_W'(vertex_count);
		end
	end

	assign few    = n < CNT_W'(MIN_VERTICES);
	assign last   = cnt_q == (n - CNT_W'(1));
	assign nb_inc = nb_q + CNT_W'(1);
	assign nb_nx  = (nb_inc == n) ? '0 : nb_inc;

	// Product low word and edge classification terms
	assign pl        = prod[MW-1:0];
	assign d2b_w     = (MW+2)'(d2a_q) - ((MW+2)'(dot_q) <<< 1) + (MW+2)'(len2_q);
	assign lo_w      = (len2_q == '0) || dot_q[MW-1] || (dot_q == '0);
	assign intr_w    = !lo_w && (dot_q < len2_q);
	assign d2_sel    = lo_q ? d2a_q : d2b_q;
	assign dy_pos    = !dy_q[DW-1] && (dy_q != '0);
	assign cross_pos = !cross_q[MW-1] && (cross_q != '0);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (qry.start) begin
					state_d = few ? S_DONE : S_TOL;
				end
			end
			S_TOL:  state_d = S_LDA;
			S_LDA:  state_d = S_LDB;
			S_LDB:  state_d = S_DIFF;
			S_DIFF: state_d = first_q ? S_SQA : S_M1;
			S_SQA:  state_d = S_SQB;
			S_SQB:  state_d = S_M1;
			S_M1:   state_d = S_M2;
			S_M2:   state_d = S_M3;
			S_M3:   state_d = S_M4;
			S_M4:   state_d = S_M5;
			S_M5:   state_d = S_M6;
			S_M6:   state_d = S_XSUB;
			S_XSUB: state_d = S_CASE;
			S_CASE: state_d = intr_q ? S_BIG1 : S_NEXT;
			S_BIG1: state_d = S_BIG2;
			S_BIG2: state_d = S_NEXT;
			S_NEXT: state_d = last ? S_DONE : S_LDB;
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Multiplier operands and vertex reads per state
	always_comb begin
		mreq = '0;
		rreq = '0;
		unique case (state_q)
			S_TOL: begin
				mreq.en   = 1'b1;
				mreq.a    = MW'(tolerance);
				mreq.b    = MW'(tolerance);
				rreq.re   = 1'b1;
				rreq.addr = '0;
			end
			S_LDA: begin
				rreq.re   = 1'b1;
				rreq.addr = VIDX_W'(1);
			end
			S_SQA: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(wx_q);
				mreq.b  = MW'(wx_q);
			end
			S_SQB: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(wy_q);
				mreq.b  = MW'(wy_q);
			end
			S_M1: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(dx_q);
				mreq.b  = MW'(dx_q);
			end
			S_M2: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(dy_q);
				mreq.b  = MW'(dy_q);
			end
			S_M3: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(wx_q);
				mreq.b  = MW'(dx_q);
			end
			S_M4: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(wy_q);
				mreq.b  = MW'(dy_q);
			end
			S_M5: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(wx_q);
				mreq.b  = MW'(dy_q);
			end
			S_M6: begin
				mreq.en = 1'b1;
				mreq.a  = MW'(wy_q);
				mreq.b  = MW'(dx_q);
			end
			S_CASE: begin
				mreq.en = intr_q;
				mreq.a  = cross_q;
				mreq.b  = cross_q;
			end
			S_BIG1: begin
				mreq.en = 1'b1;
				mreq.a  = tt_q;
				mreq.b  = len2_q;
			end
			S_NEXT: begin
				rreq.re   = 1'b1;
				rreq.addr = nb_nx[VIDX_W-1:0];
			end
			default: ;
		endcase
	end

	// Status toward the top level
	always_comb begin
		st.busy    = state_q != S_IDLE;
		st.valid   = state_q == S_DONE;
		st.in_poly = crossing_q || onb_q || near_q;
		st.by_tol  = !crossing_q && !onb_q && near_q;
	end

	// Edge datapath: write back products and fold the edge into the flags
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (qry.start) begin
					px_q       <= sx(qry.x);
					py_q       <= sx(qry.y);
					crossing_q <= 1'b0;
					onb_q      <= 1'b0;
					near_q     <= 1'b0;
					first_q    <= 1'b1;
				end
			end
			S_LDA: begin
				ax_q  <= sx(rdata[FLD_W-1:0]);
				ay_q  <= sx(rdata[2*FLD_W-1:FLD_W]);
				tt_q  <= pl;
				nb_q  <= CNT_W'(1);
				cnt_q <= '0;
			end
			S_LDB: begin
				bx_q <= sx(rdata[FLD_W-1:0]);
				by_q <= sx(rdata[2*FLD_W-1:FLD_W]);
			end
			S_DIFF: begin
				dx_q    <= bx_q - ax_q;
				dy_q    <= by_q - ay_q;
				wx_q    <= px_q - ax_q;
				wy_q    <= py_q - ay_q;
				strad_q <= (ay_q > py_q) != (by_q > py_q);
			end
			S_SQB: d2a_q <= pl;
			S_M1: begin
				if (first_q) begin
					d2a_q <= d2a_q + pl;
				end
			end
			S_M2: len2_q <= pl;
			S_M3: len2_q <= len2_q + pl;
			S_M4: dot_q <= pl;
			S_M5: dot_q <= dot_q + pl;
			S_M6: cross_q <= pl;
			S_XSUB: begin
				cross_q <= cross_q - pl;
				d2b_q   <= d2b_w[MW-1:0];
				lo_q    <= lo_w;
				intr_q  <= intr_w;
			end
			S_CASE: begin
				// toggle on a crossing to the right of the point
				if (strad_q && (dy_pos ? cross_q[MW-1] : cross_pos)) begin
					crossing_q <= !crossing_q;
				end
				// clamped to an end point: plain squared distance
				if (!intr_q) begin
					if (d2_sel == '0) begin
						onb_q <= 1'b1;
					end
					if (d2_sel <= tt_q) begin
						near_q <= 1'b1;
					end
				end
			end
			S_BIG1: begin
				crsq_q <= prod[PW-2:0];
				if (cross_q == '0) begin
					onb_q <= 1'b1;
				end
			end
			S_BIG2: begin
				// cross^2 against tol^2 * len2
				if (crsq_q <= prod[PW-2:0]) begin
					near_q <= 1'b1;
				end
			end
			S_NEXT: begin
				cnt_q   <= cnt_q + CNT_W'(1);
				nb_q    <= nb_nx;
				ax_q    <= bx_q;
				ay_q    <= by_q;
				d2a_q   <= d2b_q;
				first_q <= 1'b0;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/pip_checker.sv */
// Port-level checks for the point-in-polygon tolerance unit, bound to the top level.
// Depends on pip_pkg for the mode codes.
module pip_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                mode,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                inside_res,
	input logic                                by_tolerance
);
	import pip_pkg::*;

	// A taken query holds off the next word
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (mode == MODE_QUERY)) |=> in_stall)
		else $error("query word taken without the unit going busy");

	// A load never occupies the unit
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (mode == MODE_LOAD)) |=> !in_stall)
		else $error("load word left the unit busy");

	// A fresh result only follows a busy sequencer
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a query in work");

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(inside_res) && $stable(by_tolerance)))
		else $error("stalled result word changed");

endmodule

bind point_in_polygon_with_tolerance_unit pip_checker u_pip_checker (.*);

/* verif/tb_point_in_polygon_with_tolerance_unit.sv */
// Self-checking testbench for point_in_polygon_with_tolerance_unit: drives load and query
// words, predicts each verdict from its own copy of the polygon and registers.
// Depends on rtl/pip_pkg.sv and rtl/point_in_polygon_with_tolerance_unit.sv.
`timescale 1ns / 100ps

module tb_point_in_polygon_with_tolerance_unit;
	import pip_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int SETTLE_CYCLES  = 4;

	typedef struct packed {
		logic in_poly;
		logic by_tol;
	} verdict_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    mode;
	logic [IDX_W-1:0]        vertex_index;
	logic signed [FLD_W-1:0] coord_x;
	logic signed [FLD_W-1:0] coord_y;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    inside_res;
	logic                    by_tolerance;

	// Shadow of the polygon and registers, updated as words are accepted
	logic signed [FLD_W-1:0] vert_x [MAX_VERTICES];
	logic signed [FLD_W-1:0] vert_y [MAX_VERTICES];
	logic [VC_W-1:0]         used_count;
	logic [TOL_W-1:0]        tol_dist;

	verdict_t pending_verdicts [$];
	int       errors = 0;
	int       send_idle_pct;
	int       stall_pct;
	int       idle_cycles = 0;

	point_in_polygon_with_tolerance_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.inside_res   (inside_res),
		.by_tolerance (by_tolerance)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Even-odd crossing plus squared distance to every edge of the closed ring
	function automatic verdict_t classify_point(input logic signed [FLD_W-1:0] qx,
			input logic signed [FLD_W-1:0] qy);
		longint       px, py, ax, ay, bx, by, dx, dy, wx, wy;
		longint       len2, dot, cr, d2, tt, lhs, rhs;
		logic [127:0] cross_sq, tol_band;
		int           n, i, j;
		bit           odd, on_edge, in_band, hit_zero, hit_band;
		verdict_t     v;
		px = qx;
		py = qy;
		v = '0;
		n = (used_count > MAX_VERTICES) ? MAX_VERTICES : int'(used_count);
		if (n < MIN_VERTICES)
			return v;
		tt = longint'(tol_dist) * longint'(tol_dist);
		odd = 1'b0;
		on_edge = 1'b0;
		in_band = 1'b0;
		for (i = 0; i < n; i++) begin
			j = (i + 1) % n;
			ax = vert_x[i];
			ay = vert_y[i];
			bx = vert_x[j];
			by = vert_y[j];
			dx = bx - ax;
			dy = by - ay;
			// crossing of the horizontal ray to the right
			if ((ay > py) != (by > py)) begin
				lhs = (px - ax) * dy;
				rhs = (py - ay) * dx;
				if (dy > 0 ? lhs < rhs : lhs > rhs)
					odd = !odd;
			end
			wx = px - ax;
			wy = py - ay;
			len2 = dx * dx + dy * dy;
			dot = wx * dx + wy * dy;
			if (len2 == 0 || dot <= 0) begin
				d2 = wx * wx + wy * wy;
				hit_zero = (d2 == 0);
				hit_band = (d2 <= tt);
			end else if (dot >= len2) begin
				d2 = (px - bx) * (px - bx) + (py - by) * (py - by);
				hit_zero = (d2 == 0);
				hit_band = (d2 <= tt);
			end else begin
				// dist^2 * len2 equals cross^2, so compare against tol^2 * len2
				cr = wx * dy - wy * dx;
				cross_sq = (cr < 0) ? -cr : cr;
				cross_sq = cross_sq * cross_sq;
				tol_band = 128'(tt) * 128'(len2);
				hit_zero = (cr == 0);
				hit_band = (cross_sq <= tol_band);
			end
			on_edge |= hit_zero;
			in_band |= hit_band;
		end
		v.in_poly = odd || on_edge || in_band;
		v.by_tol  = !odd && !on_edge && in_band;
		return v;
	endfunction

	function automatic logic signed [FLD_W-1:0] clip16(input longint val);
		if (val > 32767)
			return 16'sh7fff;
		if (val < -32768)
			return 16'sh8000;
		return val[FLD_W-1:0];
	endfunction

	function automatic longint spread(input longint lim);
		return longint'($urandom_range(2 * lim)) - lim;
	endfunction

	function automatic int active_vertices();
		return (used_count > MAX_VERTICES) ? MAX_VERTICES : int'(used_count);
	endfunction

	// Present one word at the falling edge, hold it until accepted, then predict
	task automatic send_word(input logic m, input logic [IDX_W-1:0] idx,
			input logic signed [FLD_W-1:0] x, input logic signed [FLD_W-1:0] y);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		vertex_index <= idx;
		coord_x      <= x;
		coord_y      <= y;
		do
			@(posedge clk);
		while (in_stall);
		if (m == MODE_QUERY) begin
			pending_verdicts = {pending_verdicts, classify_point(x, y)};
		end else begin
			vert_x[idx] = x;
			vert_y[idx] = y;
		end
	endtask

	task automatic send_load(input int idx, input longint x, input longint y);
		send_word(MODE_LOAD, IDX_W'(idx), clip16(x), clip16(y));
	endtask

	task automatic send_query(input longint x, input longint y);
		send_word(MODE_QUERY, IDX_W'($urandom_range(MAX_VERTICES - 1)), clip16(x), clip16(y));
	endtask

	// Drop valid and wait until every verdict is back and the block is quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_VERTEX_COUNT)
			used_count = VC_W'(val);
		else
			tol_dist = TOL_W'(val);
	endtask

	// Load all slots: a ring on a square's perimeter or a scattered ring,
	// with some repeated vertices for zero-length edges
	task automatic build_polygon(input int n_eff);
		longint s, cx, cy, per, pos, x, y;
		int     i, shape;
		case ($urandom_range(2))
			0: s = 64;
			1: s = 2048;
			default: s = 32767;
		endcase
		cx = (s == 32767) ? 0 : spread(32767 - s);
		cy = (s == 32767) ? 0 : spread(32767 - s);
		shape = $urandom_range(1);
		per = 8 * s;
		for (i = 0; i < MAX_VERTICES; i++) begin
			if (i > 0 && i < n_eff && $urandom_range(99) < 8) begin
				x = vert_x[i - 1];
				y = vert_y[i - 1];
			end else if (shape == 0 && i < n_eff) begin
				pos = i * per / n_eff;
				if (pos < 2 * s) begin
					x = cx - s + pos;
					y = cy - s;
				end else if (pos < 4 * s) begin
					x = cx + s;
					y = cy - s + (pos - 2 * s);
				end else if (pos < 6 * s) begin
					x = cx + s - (pos - 4 * s);
					y = cy + s;
				end else begin
					x = cx - s;
					y = cy + s - (pos - 6 * s);
				end
			end else begin
				x = cx + spread(s);
				y = cy + spread(s);
			end
			send_load(i, x, y);
		end
	endtask

	// Pick a query point: on an edge, near one, inside the box, or anywhere
	task automatic make_query(output longint qx, output longint qy);
		int     n, i, j, m, k, r;
		longint ax, ay, bx, by, lim, xmin, xmax, ymin, ymax;
		n = active_vertices();
		r = $urandom_range(99);
		if (n < MIN_VERTICES)
			r = 85;
		if (r < 55) begin
			i = $urandom_range(n - 1);
			j = (i + 1) % n;
			ax = vert_x[i];
			ay = vert_y[i];
			bx = vert_x[j];
			by = vert_y[j];
			m = 1 << $urandom_range(3);
			k = $urandom_range(m);
			qx = ax + (bx - ax) * k / m;
			qy = ay + (by - ay) * k / m;
			if (r >= 25) begin
				lim = longint'(tol_dist) + 3;
				qx += spread(lim);
				qy += spread(lim);
			end
		end else if (r < 80) begin
			xmin = 32767;
			xmax = -32768;
			ymin = 32767;
			ymax = -32768;
			for (i = 0; i < n; i++) begin
				xmin = (vert_x[i] < xmin) ? vert_x[i] : xmin;
				xmax = (vert_x[i] > xmax) ? vert_x[i] : xmax;
				ymin = (vert_y[i] < ymin) ? vert_y[i] : ymin;
				ymax = (vert_y[i] > ymax) ? vert_y[i] : ymax;
			end
			qx = xmin - 4 + longint'($urandom_range(int'(xmax - xmin) + 8));
			qy = ymin - 4 + longint'($urandom_range(int'(ymax - ymin) + 8));
		end else if (r < 92) begin
			qx = longint'($signed(16'($urandom)));
			qy = longint'($signed(16'($urandom)));
		end else begin
			case ($urandom_range(3))
				0: qx = -32768;
				1: qx = 32767;
				2: qx = 0;
				default: qx = -1;
			endcase
			case ($urandom_range(3))
				0: qy = -32768;
				1: qy = 32767;
				2: qy = 0;
				default: qy = -1;
			endcase
		end
	endtask

	// Count left at reset: no vertices in use, so the answer is outside
	task automatic test_reset_count();
		send_query(0, 0);
		send_query(-32768, 32767);
		settle();
	endtask

	// Square ring: too few vertices, triangle, then boundary and band with
	// the reset tolerance and with zero tolerance
	task automatic test_square_boundary();
		send_load(0, -1000, -1000);
		send_load(1, 1000, -1000);
		send_load(2, 1000, 1000);
		send_load(3, -1000, 1000);
		settle();
		write_reg(REG_VERTEX_COUNT, 2);
		send_query(-1000, -1000);
		settle();
		write_reg(REG_VERTEX_COUNT, 3);
		send_query(500, -200);
		send_query(-500, 200);
		settle();
		write_reg(REG_VERTEX_COUNT, 4);
		send_query(0, 0);
		send_query(1000, 0);
		send_query(1051, 0);
		send_query(1052, 0);
		send_query(-1000, -1000);
		send_query(1036, 1036);
		settle();
		write_reg(REG_TOLERANCE, 0);
		send_query(1001, 0);
		send_query(1000, 500);
		send_query(-1000, 1000);
		settle();
	endtask

	// Zero-length edge measured to its start vertex; widest tolerance with
	// coordinates at the ends of the range
	task automatic test_degenerate_edge_and_extremes();
		send_load(3, 1000, 1000);
		settle();
		write_reg(REG_TOLERANCE, 51);
		send_query(1000, 1030);
		send_query(-1000, -1040);
		settle();
		write_reg(REG_TOLERANCE, 32767);
		send_query(32767, 32767);
		send_query(-32768, 0);
		settle();
	endtask

	// Random rings and points over four idling phases
	task automatic test_random_polygons();
		int     phase, round, k, r, cnt, tl, n_eff;
		longint qx, qy;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 45; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 45; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			for (round = 0; round < 5; round++) begin
				settle();
				r = $urandom_range(99);
				if (r < 5)
					cnt = $urandom_range(2);
				else if (r < 15)
					cnt = 3;
				else if (r < 35)
					cnt = 16;
				else if (r < 45)
					cnt = $urandom_range(31, 17);
				else
					cnt = $urandom_range(15, 4);
				r = $urandom_range(99);
				if (r < 10)
					tl = 0;
				else if (r < 15)
					tl = 32767;
				else if (r < 25)
					tl = 51;
				else if (r < 50)
					tl = $urandom_range(63);
				else if (r < 85)
					tl = $urandom_range(1023);
				else
					tl = $urandom_range(32767);
				write_reg(REG_VERTEX_COUNT, cnt);
				write_reg(REG_TOLERANCE, tl);
				n_eff = (cnt > MAX_VERTICES) ? MAX_VERTICES :
					((cnt < MIN_VERTICES) ? MAX_VERTICES : cnt);
				build_polygon(n_eff);
				for (k = 0; k < 66; k++) begin
					if ($urandom_range(99) < 6) begin
						r = $urandom_range(MAX_VERTICES - 1);
						send_load(r, longint'(vert_x[r]) + spread(300),
							longint'(vert_y[r]) + spread(300));
					end else begin
						make_query(qx, qy);
						send_query(qx, qy);
					end
				end
			end
		end
	endtask

	// Receiver: stall at random per the current phase
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Compare each taken result with the oldest expected verdict
	always @(posedge clk) begin : check_result
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got inside_res %0b by_tolerance %0b",
					$time, inside_res, by_tolerance);
			end else begin
				want = pending_verdicts.pop_front();
				if (inside_res !== want.in_poly) begin
					errors++;
					$display("%0t: inside_res expected %0b, actual %0b",
						$time, want.in_poly, inside_res);
				end
				if (by_tolerance !== want.by_tol) begin
					errors++;
					$display("%0t: by_tolerance expected %0b, actual %0b",
						$time, want.by_tol, by_tolerance);
				end
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		mode          = MODE_LOAD;
		vertex_index  = '0;
		coord_x       = '0;
		coord_y       = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		used_count    = '0;
		tol_dist      = TOL_RESET;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vert_x[i] = '0;
			vert_y[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_count();
		test_square_boundary();
		test_degenerate_edge_and_extremes();
		test_random_polygons();

		// Drain, then give late or extra results time to show
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
